FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSGE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psge assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSGE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psge assertion failed");

`endif

FILE: design/psge_pkg.sv
// Types and constants for the pad sample gate.
`default_nettype none

package psge_pkg;

  localparam int unsigned ButtonCount = 3;
  localparam int unsigned SeqWidth    = 64;
  localparam int unsigned TickWidth   = 64;
  localparam int unsigned AxisInWidth = 16;
  localparam int unsigned AxisWidth   = 9;
  localparam int unsigned BtnInWidth  = 8;
  localparam int unsigned StatusWidth = 3;

  localparam logic [BtnInWidth-1:0] BtnMask = BtnInWidth'((1 << ButtonCount) - 1);
  localparam logic signed [AxisInWidth-1:0] AxisLo = -16'sd128;
  localparam logic signed [AxisInWidth-1:0] AxisHi = 16'sd128;

  typedef enum logic [StatusWidth-1:0] {
    StOk         = 3'd0,
    StDupIdem    = 3'd1,
    StDupClash   = 3'd2,
    StBadSeq     = 3'd3,
    StBadButtons = 3'd4,
    StAxisRange  = 3'd5,
    StBackTick   = 3'd6
  } status_e;

endpackage

`default_nettype wire

FILE: design/psge_if.sv
// Valid/ready channel interfaces for pad samples and gated frames.
`default_nettype none

interface psge_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [psge_pkg::SeqWidth-1:0]         seq_num;
  logic [psge_pkg::TickWidth-1:0]        tick_val;
  logic signed [psge_pkg::AxisInWidth-1:0] axis_x;
  logic signed [psge_pkg::AxisInWidth-1:0] axis_y;
  logic [psge_pkg::BtnInWidth-1:0]       button_bits;

  modport source (output valid, seq_num, tick_val, axis_x, axis_y, button_bits,
                  input ready);
  modport sink (input valid, seq_num, tick_val, axis_x, axis_y, button_bits,
                output ready);
endinterface

interface psge_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [psge_pkg::StatusWidth-1:0]      status;
  logic                                  frame_out;
  logic [psge_pkg::SeqWidth-1:0]         out_seq;
  logic [psge_pkg::TickWidth-1:0]        out_tick;
  logic signed [psge_pkg::AxisWidth-1:0] out_x;
  logic signed [psge_pkg::AxisWidth-1:0] out_y;
  logic [psge_pkg::ButtonCount-1:0]      down_mask;
  logic [psge_pkg::ButtonCount-1:0]      pressed_mask;
  logic [psge_pkg::ButtonCount-1:0]      released_mask;
  logic                                  have_frame;

  modport source (output valid, status, frame_out, out_seq, out_tick, out_x, out_y,
                  down_mask, pressed_mask, released_mask, have_frame,
                  input ready);
  modport sink (input valid, status, frame_out, out_seq, out_tick, out_x, out_y,
                down_mask, pressed_mask, released_mask, have_frame,
                output ready);
endinterface

`default_nettype wire

FILE: design/pad_sample_gate_edge_detect.sv
// Pad sample gate: checks each gamepad sample and reports frames with button edges.
//
// in_i carries one sample word per handshake (sequence, tick, two axes, buttons).
// out_o carries one result word per sample: a status code, and when frame_out is
// set the stored frame with its down, pressed and released button masks.
// Every sample yields exactly one result word, in order.
// A sample accepted on in_i is held in the input register, checked there, and its
// result is registered in the result register that drives out_o.
// Throughput: one sample per cycle while out_o is not stalled; the gate state (last
// accepted sample) is updated in the same cycle the check result is registered, so
// the next sample is checked against it without a bubble.
// Reset clears the stored frame, so the first sample after reset skips the
// duplicate, backward sequence and backward tick checks.
// When out_o is stalled the result register holds, the input register fills,
// and in_i.ready drops until the result is taken; nothing is dropped.
`default_nettype none

module pad_sample_gate_edge_detect (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psge_in_if.sink    in_i,
  psge_out_if.source out_o
);

  localparam int unsigned Bc = psge_pkg::ButtonCount;
  localparam int unsigned Aw = psge_pkg::AxisWidth;
  localparam int unsigned Ai = psge_pkg::AxisInWidth;

  // input register
  logic                                  s1_valid_q;
  logic [psge_pkg::SeqWidth-1:0]         seq_q;
  logic [psge_pkg::TickWidth-1:0]        tick_q;
  logic signed [Ai-1:0]                  ax_q;
  logic signed [Ai-1:0]                  ay_q;
  logic [psge_pkg::BtnInWidth-1:0]       btn_q;

  // gate state
  logic                                  seen_q;
  logic [psge_pkg::SeqWidth-1:0]         pseq_q;
  logic [psge_pkg::TickWidth-1:0]        ptick_q;
  logic signed [Aw-1:0]                  px_q;
  logic signed [Aw-1:0]                  py_q;
  logic [Bc-1:0]                         pbtn_q;
  logic [Bc-1:0]                         ppress_q;
  logic [Bc-1:0]                         prel_q;

  // result register
  logic                                  ov_q;
  psge_pkg::status_e                     status_q;
  logic                                  frame_q;
  logic [psge_pkg::SeqWidth-1:0]         oseq_q;
  logic [psge_pkg::TickWidth-1:0]        otick_q;
  logic signed [Aw-1:0]                  ox_q;
  logic signed [Aw-1:0]                  oy_q;
  logic [Bc-1:0]                         odown_q;
  logic [Bc-1:0]                         opress_q;
  logic [Bc-1:0]                         orel_q;
  logic                                  ohave_q;

  logic                                  advance;
  logic                                  dup;
  logic                                  idem;
  logic                                  bad_seq;
  logic                                  bad_btn;
  logic                                  bad_axis;
  logic                                  bad_tick;
  logic signed [Ai-1:0]                  px_ext;
  logic signed [Ai-1:0]                  py_ext;
  logic [Bc-1:0]                         new_btn;
  logic [Bc-1:0]                         old_btn;
  logic [Bc-1:0]                         press_d;
  logic [Bc-1:0]                         rel_d;
  psge_pkg::status_e                     status_d;
  logic                                  take_d;
  logic                                  frame_d;

  assign advance  = s1_valid_q && (!ov_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  assign px_ext  = Ai'(px_q);
  assign py_ext  = Ai'(py_q);
  assign new_btn = btn_q[Bc-1:0];
  assign old_btn = seen_q ? pbtn_q : '0;
  assign press_d = new_btn & ~old_btn;
  assign rel_d   = old_btn & ~new_btn;

  assign dup      = seen_q && (seq_q == pseq_q);
  assign idem     = (tick_q == ptick_q) && (ax_q == px_ext) && (ay_q == py_ext)
                    && (btn_q == psge_pkg::BtnInWidth'(pbtn_q));
  assign bad_seq  = (seq_q == '0) || (seen_q && (seq_q < pseq_q));
  assign bad_btn  = (btn_q & ~psge_pkg::BtnMask) != '0;
  assign bad_axis = (ax_q < psge_pkg::AxisLo) || (ax_q > psge_pkg::AxisHi) ||
                    (ay_q < psge_pkg::AxisLo) || (ay_q > psge_pkg::AxisHi);
  assign bad_tick = seen_q && (tick_q < ptick_q);

  // priority order of the checks
  always_comb begin
    take_d  = 1'b0;
    frame_d = 1'b0;
    if (dup) begin
      status_d = idem ? psge_pkg::StDupIdem : psge_pkg::StDupClash;
      frame_d  = idem;
    end else if (bad_seq) begin
      status_d = psge_pkg::StBadSeq;
    end else if (bad_btn) begin
      status_d = psge_pkg::StBadButtons;
    end else if (bad_axis) begin
      status_d = psge_pkg::StAxisRange;
    end else if (bad_tick) begin
      status_d = psge_pkg::StBackTick;
    end else begin
      status_d = psge_pkg::StOk;
      take_d   = 1'b1;
      frame_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      seq_q  <= in_i.seq_num;
      tick_q <= in_i.tick_val;
      ax_q   <= in_i.axis_x;
      ay_q   <= in_i.axis_y;
      btn_q  <= in_i.button_bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      pseq_q   <= '0;
      ptick_q  <= '0;
      px_q     <= '0;
      py_q     <= '0;
      pbtn_q   <= '0;
      ppress_q <= '0;
      prel_q   <= '0;
    end else if (advance && take_d) begin
      seen_q   <= 1'b1;
      pseq_q   <= seq_q;
      ptick_q  <= tick_q;
      px_q     <= ax_q[Aw-1:0];
      py_q     <= ay_q[Aw-1:0];
      pbtn_q   <= new_btn;
      ppress_q <= press_d;
      prel_q   <= rel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (advance) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // frame fields come from the new sample on accept, from the stored frame on replay, else zero
  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      frame_q  <= frame_d;
      ohave_q  <= seen_q || take_d;
      if (take_d) begin
        oseq_q   <= seq_q;
        otick_q  <= tick_q;
        ox_q     <= ax_q[Aw-1:0];
        oy_q     <= ay_q[Aw-1:0];
        odown_q  <= new_btn;
        opress_q <= press_d;
        orel_q   <= rel_d;
      end else if (frame_d) begin
        oseq_q   <= pseq_q;
        otick_q  <= ptick_q;
        ox_q     <= px_q;
        oy_q     <= py_q;
        odown_q  <= pbtn_q;
        opress_q <= ppress_q;
        orel_q   <= prel_q;
      end else begin
        oseq_q   <= '0;
        otick_q  <= '0;
        ox_q     <= '0;
        oy_q     <= '0;
        odown_q  <= '0;
        opress_q <= '0;
        orel_q   <= '0;
      end
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = status_q;
  assign out_o.frame_out     = frame_q;
  assign out_o.out_seq       = oseq_q;
  assign out_o.out_tick      = otick_q;
  assign out_o.out_x         = ox_q;
  assign out_o.out_y         = oy_q;
  assign out_o.down_mask     = odown_q;
  assign out_o.pressed_mask  = opress_q;
  assign out_o.released_mask = orel_q;
  assign out_o.have_frame    = ohave_q;

endmodule

`default_nettype wire

FILE: design/psge_checker.sv
// Port-level checker for the pad sample gate, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module psge_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic [psge_pkg::StatusWidth-1:0]   status_i,
  input wire logic                               frame_out_i,
  input wire logic [psge_pkg::SeqWidth-1:0]      out_seq_i,
  input wire logic                               have_frame_i
);

  logic seen_q;

  // set once any delivered word reports a stored frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && have_frame_i) begin
      seen_q <= 1'b1;
    end
  end

  `PSGE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(status_i) && $stable(frame_out_i) && $stable(out_seq_i))
  `PSGE_ASSERT_NOW(a_frame_status, clk_i, rst_ni, out_valid_i && frame_out_i,
    status_i == psge_pkg::StOk || status_i == psge_pkg::StDupIdem)
  `PSGE_ASSERT_NOW(a_frame_have, clk_i, rst_ni, out_valid_i && frame_out_i,
    have_frame_i && out_seq_i != '0)
  `PSGE_ASSERT_NOW(a_have_sticky, clk_i, rst_ni, out_valid_i && seen_q, have_frame_i)

endmodule

bind pad_sample_gate_edge_detect psge_checker u_psge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .frame_out_i (out_o.frame_out),
  .out_seq_i   (out_o.out_seq),
  .have_frame_i(out_o.have_frame)
);

`default_nettype wire

FILE: tb/sv/pad_sample_gate_edge_detect_tb.sv
// Self-checking testbench for the pad sample gate: directed and random samples, scored in order.
`timescale 1ns / 1ps

module pad_sample_gate_edge_detect_tb;

  localparam int CycleLimit = 100000;
  localparam int DrainCycles = 10;

  typedef struct packed {
    logic [psge_pkg::SeqWidth-1:0]           seq;
    logic [psge_pkg::TickWidth-1:0]          tick;
    logic signed [psge_pkg::AxisInWidth-1:0] x;
    logic signed [psge_pkg::AxisInWidth-1:0] y;
    logic [psge_pkg::BtnInWidth-1:0]         btn;
  } pad_sample_t;

  typedef struct packed {
    psge_pkg::status_e                     status;
    logic                                  frame;
    logic [psge_pkg::SeqWidth-1:0]         seq;
    logic [psge_pkg::TickWidth-1:0]        tick;
    logic signed [psge_pkg::AxisWidth-1:0] x;
    logic signed [psge_pkg::AxisWidth-1:0] y;
    logic [psge_pkg::ButtonCount-1:0]      down;
    logic [psge_pkg::ButtonCount-1:0]      pressed;
    logic [psge_pkg::ButtonCount-1:0]      released;
    logic                                  have;
  } gate_result_t;

  logic clk;
  logic rst_n;

  psge_in_if  in_ch ();
  psge_out_if out_ch ();

  pad_sample_gate_edge_detect dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor copy of the gate state
  logic                                  gate_seen;
  logic [psge_pkg::SeqWidth-1:0]         last_seq;
  logic [psge_pkg::TickWidth-1:0]        last_tick;
  logic signed [psge_pkg::AxisWidth-1:0] last_x;
  logic signed [psge_pkg::AxisWidth-1:0] last_y;
  logic [psge_pkg::ButtonCount-1:0]      last_btn;
  logic [psge_pkg::ButtonCount-1:0]      last_pressed;
  logic [psge_pkg::ButtonCount-1:0]      last_released;

  gate_result_t results_due[$];
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic gate_result_t gate_result_for(pad_sample_t s);
    gate_result_t r;
    logic [psge_pkg::ButtonCount-1:0] old_btn;
    logic frame;
    r = '0;
    frame = 1'b0;
    if (gate_seen && s.seq == last_seq) begin
      if (s.tick == last_tick && s.x == last_x && s.y == last_y &&
          s.btn == psge_pkg::BtnInWidth'(last_btn)) begin
        r.status = psge_pkg::StDupIdem;
        frame = 1'b1;
      end else begin
        r.status = psge_pkg::StDupClash;
      end
    end else if (s.seq == '0 || (gate_seen && s.seq < last_seq)) begin
      r.status = psge_pkg::StBadSeq;
    end else if ((s.btn & ~psge_pkg::BtnMask) != '0) begin
      r.status = psge_pkg::StBadButtons;
    end else if (s.x < psge_pkg::AxisLo || s.x > psge_pkg::AxisHi ||
                 s.y < psge_pkg::AxisLo || s.y > psge_pkg::AxisHi) begin
      r.status = psge_pkg::StAxisRange;
    end else if (gate_seen && s.tick < last_tick) begin
      r.status = psge_pkg::StBackTick;
    end else begin
      old_btn = gate_seen ? last_btn : '0;
      last_pressed = s.btn[psge_pkg::ButtonCount-1:0] & ~old_btn;
      last_released = old_btn & ~s.btn[psge_pkg::ButtonCount-1:0];
      last_seq = s.seq;
      last_tick = s.tick;
      last_x = s.x[psge_pkg::AxisWidth-1:0];
      last_y = s.y[psge_pkg::AxisWidth-1:0];
      last_btn = s.btn[psge_pkg::ButtonCount-1:0];
      gate_seen = 1'b1;
      r.status = psge_pkg::StOk;
      frame = 1'b1;
    end
    if (frame) begin
      r.frame = 1'b1;
      r.seq = last_seq;
      r.tick = last_tick;
      r.x = last_x;
      r.y = last_y;
      r.down = last_btn;
      r.pressed = last_pressed;
      r.released = last_released;
    end
    r.have = gate_seen;
    return r;
  endfunction

  function automatic pad_sample_t pad_word(logic [63:0] seq, logic [63:0] tick,
                                           logic signed [15:0] x, logic signed [15:0] y,
                                           logic [7:0] btn);
    pad_sample_t s;
    s.seq = seq;
    s.tick = tick;
    s.x = x;
    s.y = y;
    s.btn = btn;
    return s;
  endfunction

  function automatic logic signed [15:0] axis_inside();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return -16'sd128;
    if (r == 1) return 16'sd128;
    if (r == 2) return 16'sd0;
    return 16'($signed($urandom_range(256)) - 128);
  endfunction

  function automatic logic signed [15:0] axis_outside();
    if ($urandom_range(1) == 0) return 16'($urandom_range(32767, 129));
    return 16'(-int'($urandom_range(32768, 129)));
  endfunction

  // mostly well-formed samples that follow the gate state, the rest broken or noise
  function automatic pad_sample_t random_pad_word();
    pad_sample_t s;
    int unsigned kind;
    s.seq = last_seq + (($urandom_range(7) == 0) ? 64'($urandom) + 64'd1
                                                 : 64'($urandom_range(3, 1)));
    s.tick = last_tick + (($urandom_range(7) == 0) ? 64'($urandom)
                                                   : 64'($urandom_range(4)));
    s.x = axis_inside();
    s.y = axis_inside();
    s.btn = 8'($urandom_range(7));
    kind = $urandom_range(99);
    if (!gate_seen || kind < 60) begin
      // keep well-formed
    end else if (kind < 72) begin
      s.seq = last_seq;
      s.tick = last_tick;
      s.x = last_x;
      s.y = last_y;
      s.btn = 8'(last_btn);
      if (kind >= 66) begin
        case ($urandom_range(3))
          0: s.tick = s.tick ^ (64'd1 << $urandom_range(63));
          1: s.x = s.x + 16'sd1;
          2: s.y = s.y - 16'sd1;
          default: s.btn = s.btn ^ (8'd1 << $urandom_range(7));
        endcase
      end
    end else if (kind < 78) begin
      s.seq = (last_seq > 64'd4 && $urandom_range(3) != 0) ?
              last_seq - 64'($urandom_range(4, 1)) : 64'd0;
    end else if (kind < 84) begin
      s.btn = 8'($urandom_range(255, 8));
    end else if (kind < 90) begin
      if ($urandom_range(1) == 0) s.x = axis_outside();
      else s.y = axis_outside();
    end else if (kind < 95) begin
      s.tick = (last_tick > 64'd16) ? last_tick - 64'($urandom_range(16, 1)) : 64'd0;
    end else begin
      // noise over every bit; the button byte guarantees a reject
      s.seq = {$urandom, $urandom};
      s.tick = {$urandom, $urandom};
      s.x = 16'($urandom);
      s.y = 16'($urandom);
      s.btn = 8'($urandom_range(255, 8));
    end
    return s;
  endfunction

  task automatic drive_sample(pad_sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.seq_num <= s.seq;
    in_ch.tick_val <= s.tick;
    in_ch.axis_x <= s.x;
    in_ch.axis_y <= s.y;
    in_ch.button_bits <= s.btn;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    results_due.push_back(gate_result_for(s));
  endtask

  task automatic test_directed();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // first sample after reset: no duplicate or backward checks
    drive_sample(pad_word(64'd0, 64'd0, 16'sd0, 16'sd0, 8'h00));
    drive_sample(pad_word(64'd1, '1, 16'sd0, 16'sd0, 8'h08));
    drive_sample(pad_word(64'd1, 64'd10, 16'sd129, 16'sd0, 8'h00));
    drive_sample(pad_word(64'd1, 64'd10, 16'sd0, -16'sd129, 8'h00));
    drive_sample(pad_word(64'd3, 64'd50, -16'sd128, 16'sd128, 8'h03));
    drive_sample(pad_word(64'd3, 64'd50, -16'sd128, 16'sd128, 8'h03));
    drive_sample(pad_word(64'd3, 64'd51, -16'sd128, 16'sd128, 8'h03));
    // same low nine bits as the stored axis, but not equal at input width
    drive_sample(pad_word(64'd3, 64'd50, 16'sh0180, 16'sd128, 8'h03));
    // duplicate check wins over the button check
    drive_sample(pad_word(64'd3, 64'd50, -16'sd128, 16'sd128, 8'h0B));
    drive_sample(pad_word(64'd2, 64'd60, 16'sd0, 16'sd0, 8'h00));
    drive_sample(pad_word(64'd0, 64'd60, 16'sd0, 16'sd0, 8'hFF));
    drive_sample(pad_word(64'd4, 64'd60, 16'sd0, 16'sd0, 8'h80));
    drive_sample(pad_word(64'd4, 64'd60, 16'sh7FFF, 16'sd0, 8'h00));
    drive_sample(pad_word(64'd4, 64'd60, 16'sd0, 16'sh8000, 8'h00));
    drive_sample(pad_word(64'd4, 64'd49, 16'sd0, 16'sd0, 8'h00));
    // equal tick is accepted
    drive_sample(pad_word(64'd4, 64'd50, 16'sd0, 16'sd0, 8'h05));
    drive_sample(pad_word(64'd4, 64'd50, 16'sd0, 16'sd0, 8'h05));
    drive_sample(pad_word(64'd9, 64'd200, 16'sd128, -16'sd128, 8'h02));
    drive_sample(pad_word(64'd10, 64'd200, -16'sd129, 16'sd0, 8'h07));
  endtask

  task automatic test_random_phase(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) drive_sample(random_pad_word());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 250;
    repeat (40) drive_sample(random_pad_word());
  endtask

  // run last: once the sequence number is at its ceiling only exact duplicates pass
  task automatic test_seq_ceiling();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    drive_sample(pad_word('1, '1, 16'sd128, -16'sd128, 8'h07));
    drive_sample(pad_word('1, '1, 16'sd128, -16'sd128, 8'h07));
    drive_sample(pad_word(64'hFFFF_FFFF_FFFF_FFFE, '1, 16'sd0, 16'sd0, 8'h00));
    drive_sample(pad_word('1, '1, 16'sd128, -16'sd128, 8'h00));
    drive_sample(pad_word(64'd0, '1, 16'sd0, 16'sd0, 8'h00));
  endtask

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : score
    gate_result_t want;
    int bad;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing pending");
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        bad = 0;
        bad += field_bad("status", want.status, out_ch.status);
        bad += field_bad("frame_out", want.frame, out_ch.frame_out);
        bad += field_bad("out_seq", want.seq, out_ch.out_seq);
        bad += field_bad("out_tick", want.tick, out_ch.out_tick);
        bad += field_bad("out_x", want.x, out_ch.out_x);
        bad += field_bad("out_y", want.y, out_ch.out_y);
        bad += field_bad("down_mask", want.down, out_ch.down_mask);
        bad += field_bad("pressed_mask", want.pressed, out_ch.pressed_mask);
        bad += field_bad("released_mask", want.released, out_ch.released_mask);
        bad += field_bad("have_frame", want.have, out_ch.have_frame);
        mismatch_count += bad;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.seq_num = '0;
    in_ch.tick_val = '0;
    in_ch.axis_x = '0;
    in_ch.axis_y = '0;
    in_ch.button_bits = '0;
    gate_seen = 1'b0;
    last_seq = '0;
    last_tick = '0;
    last_x = '0;
    last_y = '0;
    last_btn = '0;
    last_pressed = '0;
    last_released = '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(130, 34, 45);
    test_random_phase(130, 45, 34);
    test_random_phase(130, 0, 0);
    test_backpressure();
    test_seq_ceiling();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
